>>> rtl/ks_pkg.sv
// Shared types and constants for the keyed record sorter.
package ks_pkg;

  // Width of the key and of each payload word.
  localparam int unsigned WordW = 32;

  // One record as held in a cell of the sorting chain.
  typedef struct packed {
    logic signed [WordW-1:0] key;
    logic signed [WordW-1:0] payload_a;
    logic signed [WordW-1:0] payload_b;
    logic signed [WordW-1:0] payload_c;
  } rec_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic load;   // Insert the broadcast record into the chain.
    logic drain;  // Shift the chain one place toward the output.
  } cell_ctrl_t;

endpackage

>>> rtl/ks_if.sv
// Valid/ready channel interfaces for the input and result items of the sorter.
interface ks_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ks_pkg::WordW-1:0]   key;
  logic signed [ks_pkg::WordW-1:0]   payload_a;
  logic signed [ks_pkg::WordW-1:0]   payload_b;
  logic signed [ks_pkg::WordW-1:0]   payload_c;
  logic                              last;

  modport source (output valid, key, payload_a, payload_b, payload_c, last, input ready);
  modport sink   (input valid, key, payload_a, payload_b, payload_c, last, output ready);
endinterface

interface ks_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ks_pkg::WordW-1:0]   key_res;
  logic signed [ks_pkg::WordW-1:0]   payload_a_res;
  logic signed [ks_pkg::WordW-1:0]   payload_b_res;
  logic signed [ks_pkg::WordW-1:0]   payload_c_res;
  logic                              overflow;
  logic                              last_out;

  modport source (output valid, key_res, payload_a_res, payload_b_res, payload_c_res,
                  overflow, last_out, input ready);
  modport sink   (input valid, key_res, payload_a_res, payload_b_res, payload_c_res,
                  overflow, last_out, output ready);
endinterface

>>> rtl/ks_cell.sv
// One cell of the insertion sorting chain: holds a single record and its valid bit.
module ks_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ks_pkg::cell_ctrl_t ctrl_i,
  input  ks_pkg::rec_t       new_rec_i,
  input  logic               left_gt_i,
  input  logic               left_valid_i,
  input  ks_pkg::rec_t       left_rec_i,
  input  logic               right_valid_i,
  input  ks_pkg::rec_t       right_rec_i,
  output logic               gt_o,
  output logic               valid_o,
  output ks_pkg::rec_t       rec_o
);

  logic         valid_q, valid_d;
  ks_pkg::rec_t rec_q, rec_d;

  // An empty cell counts as holding an infinite key. Equal keys do not count as
  // greater, so a new record lands after the ones with the same key.
  assign gt_o = !valid_q || ($signed(rec_q.key) > $signed(new_rec_i.key));

  // Next contents: shift right and insert while loading, shift left while draining.
  always_comb begin
    valid_d = valid_q;
    rec_d   = rec_q;
    if (ctrl_i.drain) begin
      valid_d = right_valid_i;
      rec_d   = right_rec_i;
    end else if (ctrl_i.load && gt_o) begin
      if (left_gt_i) begin
        valid_d = left_valid_i;
        rec_d   = left_rec_i;
      end else begin
        valid_d = 1'b1;
        rec_d   = new_rec_i;
      end
    end
  end

  // Valid bit is control state; the record itself needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

endmodule

>>> rtl/keyed_record_sorter_top.sv
// Top level of the keyed record sorter: a chain of insertion cells and its control.
// A batch of records is loaded one item per cycle into a chain of MAX_RECORDS cells;
// each record is compared against every held key at once and slots in behind all
// keys that are less than or equal to it, so the chain is always in ascending signed
// key order and equal keys keep their arrival order. The item with last set closes
// the batch; from the next cycle the chain shifts toward the output one place per
// accepted result item, and no input item is accepted while a batch drains. Records
// that arrive when the chain is full are dropped, and every result of that batch
// then carries overflow; a dropped closing record still closes the batch. The final
// result of each batch carries last_out.
module keyed_record_sorter_top #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ks_in_if.sink    in_i,
  ks_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  logic [CntW-1:0]    fill_q, fill_d;
  logic               ovf_q, ovf_d;
  logic               drain_q, drain_d;
  logic               in_acc, out_acc, full;
  ks_pkg::cell_ctrl_t ctrl;
  ks_pkg::rec_t       new_rec;

  logic               gt    [MAX_RECORDS];
  logic               vld   [MAX_RECORDS+1];
  ks_pkg::rec_t       rec   [MAX_RECORDS+1];

  // Handshakes: input only while loading, output only while draining.
  assign in_i.ready  = !drain_q;
  assign in_acc      = in_i.valid && !drain_q;
  assign out_o.valid = drain_q;
  assign out_acc     = drain_q && out_o.ready;
  assign full        = (fill_q == CntW'(MAX_RECORDS));

  assign new_rec.key       = in_i.key;
  assign new_rec.payload_a = in_i.payload_a;
  assign new_rec.payload_b = in_i.payload_b;
  assign new_rec.payload_c = in_i.payload_c;

  assign ctrl.load  = in_acc && !full;
  assign ctrl.drain = out_acc;

  // Chain ends: nothing is greater to the left of the first cell, nothing to the
  // right of the last one.
  assign gt[0]            = 1'b0;
  assign vld[0]           = 1'b0;
  assign rec[0]           = new_rec;
  assign vld[MAX_RECORDS] = 1'b0;
  assign rec[MAX_RECORDS] = new_rec;

  // The chain of cells; cell i sits at index i+1 of the link arrays.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic         r_valid;
    ks_pkg::rec_t r_rec;
    logic         c_gt, c_valid;
    ks_pkg::rec_t c_rec;

    if (i == MAX_RECORDS - 1) begin : g_end
      assign r_valid = vld[MAX_RECORDS];
      assign r_rec   = rec[MAX_RECORDS];
    end else begin : g_mid
      assign r_valid = g_cell[i+1].c_valid;
      assign r_rec   = g_cell[i+1].c_rec;
    end

    ks_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_rec_i    (new_rec),
      .left_gt_i    (gt[i]),
      .left_valid_i (vld[i]),
      .left_rec_i   (rec[i]),
      .right_valid_i(r_valid),
      .right_rec_i  (r_rec),
      .gt_o         (c_gt),
      .valid_o      (c_valid),
      .rec_o        (c_rec)
    );

    if (i < MAX_RECORDS - 1) begin : g_link
      assign gt[i+1]  = c_gt;
      assign vld[i+1] = c_valid;
      assign rec[i+1] = c_rec;
    end
  end

  // The head cell drives the result item.
  assign out_o.key_res       = g_cell[0].c_rec.key;
  assign out_o.payload_a_res = g_cell[0].c_rec.payload_a;
  assign out_o.payload_b_res = g_cell[0].c_rec.payload_b;
  assign out_o.payload_c_res = g_cell[0].c_rec.payload_c;
  assign out_o.overflow      = ovf_q;
  assign out_o.last_out      = (fill_q == CntW'(1));

  // Batch bookkeeping: fill count, overflow flag and load/drain phase.
  always_comb begin
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    drain_d = drain_q;
    if (in_acc) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        fill_d = fill_q + CntW'(1);
      end
      if (in_i.last) begin
        drain_d = 1'b1;
      end
    end
    if (out_acc) begin
      fill_d = fill_q - CntW'(1);
      if (fill_q == CntW'(1)) begin
        drain_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      drain_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      drain_q <= drain_d;
    end
  end

  // While draining, the head cell always holds a record.
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> g_cell[0].c_valid)
    else $error("draining with an empty head cell");

  // The fill count never passes the chain length.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MAX_RECORDS))
    else $error("fill count beyond chain length");

  // A closing item always starts a drain in the next cycle.
  a_close_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last) |=> drain_q)
    else $error("closing item did not start a drain");

  // The final result of a batch returns the block to loading with counters cleared.
  a_batch_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_out) |=> (!drain_q && fill_q == '0 && !ovf_q))
    else $error("batch end did not clear state");

endmodule

>>> tb/sv/keyed_record_sorter_top_tb.sv
// Self-checking testbench for the keyed record sorter with directed and random batches.
module keyed_record_sorter_top_tb;

  localparam int unsigned WordW       = ks_pkg::WordW;
  localparam int unsigned MaxRec      = 64;
  localparam int unsigned RandomItems = 50;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainGuard  = 2 * MaxRec + 16;

  localparam logic signed [WordW-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [WordW-1:0] KeyMax = 32'sh7fff_ffff;

  // One sorted record as it should leave the block.
  typedef struct {
    ks_pkg::rec_t rec;
    logic overflow;
    logic last_out;
  } sorted_rec_t;

  logic clk;
  logic rst_n;

  ks_in_if  rec_in ();
  ks_out_if rec_out ();

  keyed_record_sorter_top #(
    .MAX_RECORDS(MaxRec)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (rec_in),
    .out_o (rec_out)
  );

  // Records of the batch still open, and the sorted records still owed by the block.
  ks_pkg::rec_t  open_batch_q[$];
  bit            batch_dropped;
  sorted_rec_t   sorted_q[$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  int unsigned   stall_left;
  bit            src_steady;
  bit            snk_steady;

  // Clock with a period of 12.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Mostly short gaps, a few long ones, none in a steady stretch.
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  // Keys lean toward duplicates and extremes so that ordering and stability get exercised.
  function automatic logic [WordW-1:0] rand_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      return $urandom();
    end else if (sel < 70) begin
      return $signed($urandom_range(0, 16)) - 8;
    end else if (sel < 90) begin
      case ($urandom_range(0, 4))
        0: return KeyMin;
        1: return KeyMax;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end else if (sel < 95) begin
      return KeyMax - $urandom_range(0, 3);
    end
    return KeyMin + $urandom_range(0, 3);
  endfunction

  function automatic ks_pkg::rec_t make_rec(logic [WordW-1:0] key, logic [WordW-1:0] pa,
                                            logic [WordW-1:0] pb, logic [WordW-1:0] pc);
    ks_pkg::rec_t r;
    r.key       = key;
    r.payload_a = pa;
    r.payload_b = pb;
    r.payload_c = pc;
    return r;
  endfunction

  function automatic ks_pkg::rec_t rand_rec();
    return make_rec(rand_key(), $urandom(), $urandom(), $urandom());
  endfunction

  // Collects the batch; on the closing record, stable-sorts it and queues the results.
  function automatic void predict_sort(ks_pkg::rec_t rec, bit last);
    ks_pkg::rec_t ordered[$];
    sorted_rec_t  exp;
    int           pos;
    if (open_batch_q.size() < MaxRec) begin
      open_batch_q.push_back(rec);
    end else begin
      batch_dropped = 1'b1;
    end
    if (last) begin
      foreach (open_batch_q[i]) begin
        pos = ordered.size();
        while (pos > 0 && $signed(ordered[pos-1].key) > $signed(open_batch_q[i].key)) begin
          pos--;
        end
        ordered.insert(pos, open_batch_q[i]);
      end
      foreach (ordered[i]) begin
        exp.rec      = ordered[i];
        exp.overflow = batch_dropped;
        exp.last_out = (i == ordered.size() - 1);
        sorted_q.push_back(exp);
      end
      open_batch_q.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  // Drives one record after a random gap and waits until the block takes it.
  task automatic send_record(input ks_pkg::rec_t rec, input bit last);
    int unsigned gap;
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      @(negedge clk);
      rec_in.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rec_in.valid     <= 1'b1;
    rec_in.key       <= rec.key;
    rec_in.payload_a <= rec.payload_a;
    rec_in.payload_b <= rec.payload_b;
    rec_in.payload_c <= rec.payload_c;
    rec_in.last      <= last;
    @(posedge clk);
    while (!rec_in.ready) @(posedge clk);
    predict_sort(rec, last);
  endtask

  // Sends a batch of random records of the given length, closing it on the final one.
  task automatic send_random_batch(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_record(rand_rec(), i == len - 1);
    end
  endtask

  // Single-record batches carrying an extreme value in every field.
  task automatic test_single_records();
    send_record(make_rec(KeyMax, KeyMin, KeyMax, 0), 1'b1);
    send_record(make_rec(KeyMin, KeyMax, 0, KeyMin), 1'b1);
    send_record(make_rec(0, -1, -1, -1), 1'b1);
  endtask

  // Signed ordering across the sign boundary; payload_a tags arrival order for stability.
  task automatic test_signed_order();
    logic [WordW-1:0] keys[9];
    keys = '{KeyMax, KeyMin, 0, -1, 1, KeyMin, KeyMax, 0, -1};
    foreach (keys[i]) begin
      send_record(make_rec(keys[i], i, ~i, $urandom()), i == 8);
    end
  endtask

  // A batch arriving in descending order, then one already ascending.
  task automatic test_reverse_order();
    for (int i = 0; i < 8; i++) begin
      send_record(make_rec(5 - i, $urandom(), $urandom(), $urandom()), i == 7);
    end
    for (int i = 0; i < 3; i++) begin
      send_record(make_rec(i * 1000 - 1000, $urandom(), $urandom(), $urandom()), i == 2);
    end
  endtask

  // Exactly full batches: no record is dropped, once without any idling.
  task automatic test_full_batch();
    src_steady = 1'b1;
    snk_steady = 1'b1;
    send_random_batch(MaxRec);
    src_steady = 1'b0;
    snk_steady = 1'b0;
    send_random_batch(MaxRec);
  endtask

  // Batches past capacity drop the extra records and the closing one; a short batch follows.
  task automatic test_overflow();
    send_random_batch(MaxRec + 1);
    send_random_batch(MaxRec + $urandom_range(2, 8));
    send_random_batch(2);
  endtask

  // Random batch lengths, mostly short, with occasional full and overflowing ones.
  task automatic test_random_batches();
    int unsigned sent;
    int unsigned r;
    int unsigned len;
    sent = 0;
    while (sent < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = $urandom_range(1, 8);
      end else if (r < 90) begin
        len = $urandom_range(9, 32);
      end else if (r < 98) begin
        len = $urandom_range(33, MaxRec);
      end else begin
        len = $urandom_range(MaxRec + 1, MaxRec + 8);
      end
      src_steady = ($urandom_range(0, 3) == 0);
      snk_steady = ($urandom_range(0, 3) == 0);
      send_random_batch(len);
      sent += len;
    end
    src_steady = 1'b0;
    snk_steady = 1'b0;
  endtask

  // Result side: ready drops for random stretches unless in a steady stretch.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      rec_out.ready <= 1'b0;
    end else begin
      rec_out.ready <= 1'b1;
      stall_left    <= pick_gap(snk_steady);
    end
  end

  function automatic void check_field(string name, logic [WordW-1:0] want,
                                      logic [WordW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every accepted result item with the oldest expected record.
  always @(posedge clk) begin
    sorted_rec_t exp;
    if (rst_n && rec_out.valid && rec_out.ready) begin
      if (sorted_q.size() == 0) begin
        $error("result item with no record expected: key_res 0x%08h", rec_out.key_res);
        mismatch_count++;
      end else begin
        exp = sorted_q.pop_front();
        check_field("key_res", exp.rec.key, rec_out.key_res);
        check_field("payload_a_res", exp.rec.payload_a, rec_out.payload_a_res);
        check_field("payload_b_res", exp.rec.payload_b, rec_out.payload_b_res);
        check_field("payload_c_res", exp.rec.payload_c, rec_out.payload_c_res);
        check_field("overflow", WordW'(exp.overflow), WordW'(rec_out.overflow));
        check_field("last_out", WordW'(exp.last_out), WordW'(rec_out.last_out));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    rec_in.valid     = 1'b0;
    rec_in.key       = '0;
    rec_in.payload_a = '0;
    rec_in.payload_b = '0;
    rec_in.payload_c = '0;
    rec_in.last      = 1'b0;
    rec_out.ready    = 1'b0;
    stall_left       = 0;
    batch_dropped    = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    src_steady       = 1'b0;
    snk_steady       = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_records();
    test_signed_order();
    test_reverse_order();
    test_full_batch();
    test_overflow();
    test_random_batches();

    @(negedge clk);
    rec_in.valid <= 1'b0;
    rec_in.last  <= 1'b0;

    // Let the last batch drain, then watch a while for stray result items.
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (DrainGuard) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
